@@ rtl/assert_macros.svh @@
// concurrent assertion helpers, clocked on clk, using rst from the enclosing scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/itsa_pkg.sv @@
`timescale 1ns / 1ps
package itsa_pkg;

  localparam int ENTRIES = 1024;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int INDEX_W = 16;
  localparam int RANGE_W = INDEX_W + 1;
  localparam int VALUE_W = 64;
  localparam int FOUND_W = 10;
  localparam int CFG_W   = 10;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] FIRST_ALLOC_RESET = CFG_W'(16);

  // register number taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_FIRST_ALLOC = '0;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_ALLOC  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RD_WAIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/itsa_ifs.sv @@
`timescale 1ns / 1ps
interface itsa_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [itsa_pkg::INDEX_W-1:0]  index;
  logic [itsa_pkg::VALUE_W-1:0]  value;

  modport source (output valid, mode, index, value, input ready);
  modport sink (input valid, mode, index, value, output ready);
endinterface

interface itsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [itsa_pkg::VALUE_W-1:0]  read_value;
  logic [itsa_pkg::FOUND_W-1:0]  found_index;

  modport source (output valid, status, read_value, found_index, input ready);
  modport sink (input valid, status, read_value, found_index, output ready);
endinterface

@@ rtl/itsa_ram.sv @@
`timescale 1ns / 1ps
module itsa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/itsa_cfg.sv @@
`timescale 1ns / 1ps
module itsa_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [itsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [itsa_pkg::PDATA_W-1:0]  pwdata,
  output logic [itsa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [itsa_pkg::CFG_W-1:0]    first_alloc
);

  logic hit;
  logic wr;

  assign hit    = paddr[itsa_pkg::PADDR_W-1:2] == itsa_pkg::REG_FIRST_ALLOC;
  assign wr     = psel && penable && pwrite && hit;
  assign pready = 1'b1;
  assign prdata = hit ? itsa_pkg::PDATA_W'(first_alloc) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_alloc <= itsa_pkg::FIRST_ALLOC_RESET;
    end else if (wr) begin
      first_alloc <= pwdata[itsa_pkg::CFG_W-1:0];
    end
  end

endmodule

@@ rtl/itsa_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module itsa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  itsa_cmd_if.sink                      cmd,
  itsa_rsp_if.source                    rsp,
  input  logic [itsa_pkg::CFG_W-1:0]    first_alloc,
  output logic                          ram_we,
  output logic [itsa_pkg::ADDR_W-1:0]   ram_waddr,
  output logic [itsa_pkg::VALUE_W-1:0]  ram_wdata,
  output logic [itsa_pkg::ADDR_W-1:0]   ram_raddr,
  input  logic [itsa_pkg::VALUE_W-1:0]  ram_rdata
);

  localparam logic [itsa_pkg::ADDR_W-1:0] LAST = itsa_pkg::ADDR_W'(itsa_pkg::ENTRIES - 1);

  itsa_pkg::state_t state, state_next;

  logic [itsa_pkg::ADDR_W-1:0]  clr_cnt;
  logic [1:0]                   op_mode;
  logic [itsa_pkg::INDEX_W-1:0] op_index;
  logic [itsa_pkg::VALUE_W-1:0] op_value;
  logic [itsa_pkg::ADDR_W-1:0]  scan_addr, scan_addr_next;
  logic [itsa_pkg::ADDR_W-1:0]  cmp_addr;
  logic                         cmp_valid;

  logic                         res_status, res_status_next;
  logic [itsa_pkg::VALUE_W-1:0] res_read, res_read_next;
  logic [itsa_pkg::FOUND_W-1:0] res_found, res_found_next;

  logic                         out_valid, out_valid_next;
  logic                         out_status;
  logic [itsa_pkg::VALUE_W-1:0] out_read;
  logic [itsa_pkg::FOUND_W-1:0] out_found;
  logic                         out_load;

  itsa_pkg::mode_t              mode;
  logic                         idx_in_range;
  logic                         set_ok;
  logic [itsa_pkg::CFG_W-1:0]   alloc_start;
  logic                         alloc_ok;
  logic [itsa_pkg::VALUE_W-1:0] key;
  logic                         hit;
  logic                         at_last;
  logic                         cmd_accept;

  assign mode         = itsa_pkg::mode_t'(op_mode);
  assign idx_in_range = {1'b0, op_index} < itsa_pkg::RANGE_W'(itsa_pkg::ENTRIES);
  assign set_ok       = idx_in_range && (op_index != '0);
  // a boundary of zero behaves as one
  assign alloc_start  = (first_alloc == '0) ? itsa_pkg::CFG_W'(1) : first_alloc;
  assign alloc_ok     = itsa_pkg::RANGE_W'(alloc_start) < itsa_pkg::RANGE_W'(itsa_pkg::ENTRIES);
  assign key          = (mode == itsa_pkg::MODE_SEARCH) ? op_value : '0;
  assign hit          = cmp_valid && (ram_rdata == key);
  assign at_last      = cmp_addr == LAST;
  assign cmd_accept   = cmd.valid && cmd.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      itsa_pkg::ST_CLEAR: begin
        if (clr_cnt == LAST) begin
          state_next = itsa_pkg::ST_IDLE;
        end
      end
      itsa_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = itsa_pkg::ST_EXEC;
        end
      end
      itsa_pkg::ST_EXEC: begin
        unique case (mode)
          itsa_pkg::MODE_SET:    state_next = itsa_pkg::ST_FINISH;
          itsa_pkg::MODE_GET:    state_next = idx_in_range ? itsa_pkg::ST_RD_WAIT
                                                           : itsa_pkg::ST_FINISH;
          itsa_pkg::MODE_SEARCH: state_next = (op_value != '0) ? itsa_pkg::ST_SCAN
                                                               : itsa_pkg::ST_FINISH;
          itsa_pkg::MODE_ALLOC:  state_next = alloc_ok ? itsa_pkg::ST_SCAN
                                                       : itsa_pkg::ST_FINISH;
          default:               state_next = itsa_pkg::ST_FINISH;
        endcase
      end
      itsa_pkg::ST_RD_WAIT: begin
        state_next = itsa_pkg::ST_FINISH;
      end
      itsa_pkg::ST_SCAN: begin
        if (hit || (cmp_valid && at_last)) begin
          state_next = itsa_pkg::ST_FINISH;
        end
      end
      itsa_pkg::ST_FINISH: begin
        if (!out_valid || rsp.ready) begin
          state_next = itsa_pkg::ST_IDLE;
        end
      end
      default: state_next = itsa_pkg::ST_CLEAR;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    cmd.ready       = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = clr_cnt;
    ram_wdata       = '0;
    ram_raddr       = scan_addr;
    scan_addr_next  = scan_addr;
    res_status_next = res_status;
    res_read_next   = res_read;
    res_found_next  = res_found;
    out_load        = 1'b0;
    unique case (state)
      itsa_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      itsa_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
      end
      itsa_pkg::ST_EXEC: begin
        res_status_next = (mode == itsa_pkg::MODE_SET) && !set_ok;
        res_read_next   = '0;
        res_found_next  = '0;
        ram_waddr       = op_index[itsa_pkg::ADDR_W-1:0];
        ram_wdata       = op_value;
        ram_we          = (mode == itsa_pkg::MODE_SET) && set_ok;
        ram_raddr       = op_index[itsa_pkg::ADDR_W-1:0];
        scan_addr_next  = (mode == itsa_pkg::MODE_SEARCH) ? itsa_pkg::ADDR_W'(1)
                                                          : itsa_pkg::ADDR_W'(alloc_start);
      end
      itsa_pkg::ST_RD_WAIT: begin
        res_read_next = ram_rdata;
      end
      itsa_pkg::ST_SCAN: begin
        scan_addr_next = scan_addr + 1'b1;
        if (hit) begin
          res_found_next = itsa_pkg::FOUND_W'(cmp_addr);
        end
      end
      itsa_pkg::ST_FINISH: begin
        out_load = !out_valid || rsp.ready;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itsa_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= (state == itsa_pkg::ST_CLEAR) ? clr_cnt + 1'b1 : clr_cnt;
      // read data comes back in the cycle after the scan address is presented
      cmp_valid <= state == itsa_pkg::ST_SCAN;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      op_mode  <= cmd.mode;
      op_index <= cmd.index;
      op_value <= cmd.value;
    end
    scan_addr  <= scan_addr_next;
    cmp_addr   <= scan_addr;
    res_status <= res_status_next;
    res_read   <= res_read_next;
    res_found  <= res_found_next;
    if (out_load) begin
      out_status <= res_status;
      out_read   <= res_read;
      out_found  <= res_found;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_read;
  assign rsp.found_index = out_found;

  `ASSERT_ALWAYS(a_clear_after_reset, $fell(rst) |-> state == itsa_pkg::ST_CLEAR)
  `ASSERT_RST(a_no_write_entry0, (ram_we && state != itsa_pkg::ST_CLEAR) |-> ram_waddr != '0)
  `ASSERT_RST(a_scan_lag, (state == itsa_pkg::ST_SCAN && cmp_valid) |-> itsa_pkg::ADDR_W'(cmp_addr + 1'b1) == scan_addr)
  `ASSERT_RST(a_rsp_from_finish, $rose(out_valid) |-> $past(state == itsa_pkg::ST_FINISH))

endmodule

@@ rtl/indexed_table_with_search_and_alloc.sv @@
`timescale 1ns / 1ps
// indexed table of 64-bit entries with set, get, search by value and free-slot lookup
// cmd channel (valid/ready) carries mode, index and value; one rsp item comes back per
// cmd item with status, read_value and found_index, in order
// first_allocatable_index sits at apb byte address 0; write it only while idle
// after reset all 1024 entries are swept to zero, one entry a cycle, while cmd.ready
// stays low; apb writes are taken meanwhile
// one item at a time: cmd.ready is high only while no item is in progress; the next item
// is taken once the result of the previous one has moved into the output register
// set writes the entry in EXEC when the index is valid; get reads it in EXEC and
// captures the data in RD_WAIT, which an out-of-range get skips; search and allocate
// read one entry a cycle through the single table read port and compare it in the cycle
// after, until a hit or the last entry; a search for zero skips the scan
// the result sits in an output register; while rsp.ready is low it holds, and the next
// cmd item is still accepted and worked on, waiting at its end until the register frees
module indexed_table_with_search_and_alloc (
  input  logic                          clk,
  input  logic                          rst,
  itsa_cmd_if.sink                      cmd,
  itsa_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [itsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [itsa_pkg::PDATA_W-1:0]  pwdata,
  output logic [itsa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  logic [itsa_pkg::CFG_W-1:0]   first_alloc;
  logic                         ram_we;
  logic [itsa_pkg::ADDR_W-1:0]  ram_waddr;
  logic [itsa_pkg::VALUE_W-1:0] ram_wdata;
  logic [itsa_pkg::ADDR_W-1:0]  ram_raddr;
  logic [itsa_pkg::VALUE_W-1:0] ram_rdata;

  itsa_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .first_alloc (first_alloc)
  );

  itsa_ram #(
    .DEPTH (itsa_pkg::ENTRIES),
    .WIDTH (itsa_pkg::VALUE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  itsa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rsp         (rsp),
    .first_alloc (first_alloc),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

endmodule
